[hdl/prbs_frame_checker_macros.svh]
// Assertion macros used by the PRBS frame checker RTL.
`ifndef PRBS_FRAME_CHECKER_MACROS_SVH
`define PRBS_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PFC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prbs_frame_checker: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prbs_frame_checker: next-cycle check failed");

`endif

[hdl/pfc_pkg.sv]
// Types and constants of the PRBS frame checker.
package pfc_pkg;

  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned DATA_BITS  = 32;
  localparam int unsigned CFG_BITS   = 32;
  localparam int unsigned ADDR_BITS  = 3;
  localparam int unsigned OUT_BYTES_BITS = 104;

  localparam logic [31:0] TAP_MASK_RESET  = 32'h8000_0046;
  localparam logic        WORD_MODE_RESET = 1'b1;

  typedef enum logic {
    REG_WORD_MODE = 1'b0,
    REG_TAP_MASK  = 1'b1
  } reg_index_t;

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_TOO_SHORT = 3'd1,
    ERR_LENGTH    = 3'd2,
    ERR_SEQUENCE  = 3'd3,
    ERR_DATA      = 3'd4
  } error_kind_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] byte_total;
    logic [COUNT_BITS-1:0] frame_total;
    logic [COUNT_BITS-1:0] error_total;
    error_kind_t           error_kind;
    logic                  frame_ok;
  } result_t;

  localparam int unsigned RESULT_BITS = $bits(result_t);

endpackage

[hdl/prbs_frame_checker.sv]
// PRBS frame checker top level: frame parsing, LFSR compare, counters, output skid.
//
//  channel | direction | handshake               | payload
//  s_*     | in        | s_tvalid / s_tready     | s_tdata data_word, s_tuser operation, s_tlast
//  m_*     | out       | m_tvalid / m_tready     | m_tdata frame_ok .. byte_total
//  apb     | in        | psel, penable, pready   | paddr, pwdata, prdata
//
// One input transaction per cycle while s_tready is high, one LFSR step per data word
// after the two header words; the result of a frame is registered when its last word is taken.
// An output register plus one skid register decouple the sides: s_tready
// drops only while the skid register holds a result.
// rst is synchronous, active high, and returns configuration and frame state
// to their defaults.
`include "prbs_frame_checker_macros.svh"

module prbs_frame_checker
  import pfc_pkg::*;
#(
  parameter int unsigned MAX_WORD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [DATA_BITS-1:0]      s_tdata,   // [31:0] data_word
  input  logic [0:0]                s_tuser,   // [0] operation
  input  logic                      s_tlast,   // last
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_BYTES_BITS-1:0] m_tdata,   // [0] frame_ok, [3:1] error_kind,
                                               // [35:4] error_total, [67:36] frame_total,
                                               // [99:68] byte_total, [103:100] zero
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_BITS-1:0]      paddr,
  input  logic [CFG_BITS-1:0]       pwdata,
  output logic [CFG_BITS-1:0]       prdata,
  output logic                      pready
);

  localparam int unsigned W = MAX_WORD_BITS;
  localparam logic [W-1:0] WIDE_MASK   = '1;
  localparam logic [W-1:0] NARROW_MASK = W'(32'h0000_FFFF);

  logic                  word_mode;
  logic [31:0]           tap_mask;

  logic [W-1:0]          next_sequence, next_sequence_next;
  logic [COUNT_BITS-1:0] word_index, word_index_next;
  logic [W-1:0]          header_sequence, header_sequence_next;
  logic [W-1:0]          header_length, header_length_next;
  logic [W-1:0]          lfsr_expected, lfsr_expected_next;
  logic                  data_mismatch_seen, data_mismatch_seen_next;
  logic [COUNT_BITS-1:0] error_counter, error_counter_next;
  logic [COUNT_BITS-1:0] frame_counter, frame_counter_next;
  logic [COUNT_BITS-1:0] byte_counter, byte_counter_next;

  logic                  out_valid;
  result_t               out_result;
  logic                  skid_valid;
  result_t               skid_result;

  logic                  in_fire;
  logic                  cfg_write;
  logic [W-1:0]          word_mask;
  logic [W-1:0]          word;
  logic [W-1:0]          lfsr_cur;
  logic                  lfsr_fb;
  logic [W-1:0]          lfsr_calc;
  logic [COUNT_BITS:0]   words;
  logic [COUNT_BITS-1:0] byte_inc;
  logic [W-1:0]          hs;
  error_kind_t           kind;
  logic                  res_valid;
  result_t               res;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign s_tready  = !skid_valid;
  assign in_fire   = s_tvalid && s_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {{(OUT_BYTES_BITS - RESULT_BITS){1'b0}}, out_result};

  always_comb begin
    unique case (reg_index_t'(paddr[2]))
      REG_WORD_MODE: prdata = {{(CFG_BITS-1){1'b0}}, word_mode};
      REG_TAP_MASK:  prdata = tap_mask;
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    word_mask = word_mode ? WIDE_MASK : NARROW_MASK;
    word      = s_tdata[W-1:0] & word_mask;
    lfsr_cur  = lfsr_expected & word_mask;
    lfsr_fb   = ^(lfsr_cur & tap_mask[W-1:0]);
    lfsr_calc = {lfsr_cur[W-2:0], lfsr_fb} & word_mask;
    words     = {1'b0, word_index} + (COUNT_BITS+1)'(1);
    byte_inc  = word_mode ? {words[COUNT_BITS-3:0], 2'b00} : {words[COUNT_BITS-2:0], 1'b0};
    hs        = header_sequence & word_mask;

    next_sequence_next      = next_sequence;
    word_index_next         = word_index;
    header_sequence_next    = header_sequence;
    header_length_next      = header_length;
    lfsr_expected_next      = lfsr_expected;
    data_mismatch_seen_next = data_mismatch_seen;
    error_counter_next      = error_counter;
    frame_counter_next      = frame_counter;
    byte_counter_next       = byte_counter;
    kind                    = ERR_NONE;
    res_valid               = 1'b0;

    if (in_fire) begin
      if (op_t'(s_tuser[0]) == OP_CLEAR) begin
        error_counter_next = '0;
        frame_counter_next = '0;
        byte_counter_next  = '0;
      end else begin
        priority if (word_index == '0) begin
          header_sequence_next = word;
          lfsr_expected_next   = word;
        end else if (word_index == COUNT_BITS'(1)) begin
          header_length_next = word;
        end else begin
          lfsr_expected_next = lfsr_calc;
          if (lfsr_calc != word) begin
            data_mismatch_seen_next = 1'b1;
          end
        end

        if (word_index != '1) begin
          word_index_next = word_index + COUNT_BITS'(1);
        end

        if (s_tlast) begin
          res_valid = 1'b1;
          if (words < (COUNT_BITS+1)'(3)) begin
            kind = ERR_TOO_SHORT;
          end else begin
            frame_counter_next = frame_counter + COUNT_BITS'(1);
            byte_counter_next  = byte_counter + byte_inc;
            if ((COUNT_BITS+1)'(header_length & word_mask) + (COUNT_BITS+1)'(1) != words) begin
              kind = ERR_LENGTH;
            end else begin
              if (next_sequence != '0 && next_sequence != hs) begin
                kind = ERR_SEQUENCE;
              end
              next_sequence_next = (hs + W'(1)) & word_mask;
              if (kind == ERR_NONE && data_mismatch_seen_next) begin
                kind = ERR_DATA;
              end
            end
          end
          if (kind != ERR_NONE) begin
            error_counter_next = error_counter + COUNT_BITS'(1);
          end
          word_index_next         = '0;
          data_mismatch_seen_next = 1'b0;
        end
      end
    end

    res.frame_ok    = (kind == ERR_NONE);
    res.error_kind  = kind;
    res.error_total = error_counter_next;
    res.frame_total = frame_counter_next;
    res.byte_total  = byte_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_mode <= WORD_MODE_RESET;
      tap_mask  <= TAP_MASK_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_t'(paddr[2]))
        REG_WORD_MODE: word_mode <= pwdata[0];
        REG_TAP_MASK:  tap_mask  <= pwdata;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_sequence      <= '0;
      word_index         <= '0;
      header_sequence    <= '0;
      header_length      <= '0;
      lfsr_expected      <= '0;
      data_mismatch_seen <= 1'b0;
      error_counter      <= '0;
      frame_counter      <= '0;
      byte_counter       <= '0;
    end else begin
      next_sequence      <= next_sequence_next;
      word_index         <= word_index_next;
      header_sequence    <= header_sequence_next;
      header_length      <= header_length_next;
      lfsr_expected      <= lfsr_expected_next;
      data_mismatch_seen <= data_mismatch_seen_next;
      error_counter      <= error_counter_next;
      frame_counter      <= frame_counter_next;
      byte_counter       <= byte_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_result <= skid_result;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (res_valid) begin
        out_result <= res;
        out_valid  <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (res_valid) begin
      skid_result <= res;
      skid_valid  <= 1'b1;
    end
  end

  `PFC_ASSERT_IMPLY(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `PFC_ASSERT_NEXT(a_skid_drains, clk, rst, out_valid && m_tready && skid_valid, out_valid && !skid_valid)
  `PFC_ASSERT_IMPLY(a_ok_matches_kind, clk, rst, out_valid, out_result.frame_ok == (out_result.error_kind == ERR_NONE))
  `PFC_ASSERT_NEXT(a_last_restarts_frame, clk, rst, in_fire && s_tlast && !s_tuser[0], word_index == '0 && !data_mismatch_seen)

endmodule
